/* rtl/pfe_pkg.sv */
`default_nettype none

package pfe_pkg;

    localparam int unsigned LETTER_COUNT = 26;
    localparam int unsigned CELL_COUNT   = 25;
    localparam int unsigned LETTER_W     = 5;

    localparam logic [LETTER_W-1:0] LET_I = 5'd8;
    localparam logic [LETTER_W-1:0] LET_J = 5'd9;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_ADD_KEY = 2'd1,
        OP_FINISH  = 2'd2,
        OP_ENCRYPT = 2'd3
    } pfe_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REJECT    = 2'd1,
        ST_NOT_READY = 2'd2
    } pfe_status_t;

    // what the result register takes in a given cycle
    typedef enum logic [2:0] {
        RES_HOLD,
        RES_ZERO,
        RES_REJECT,
        RES_NOT_READY,
        RES_CIPHER
    } pfe_res_t;

    typedef struct packed {
        logic     load_in;
        logic     clear;
        logic     add_key;
        logic     walk_start;
        logic     walk_step;
        logic     pos_rd;
        logic     cell_rd;
        pfe_res_t res_sel;
        logic     load_out;
    } pfe_cmd_t;

    typedef struct packed {
        pfe_op_t op;
        logic    ready;
        logic    range_bad;
        logic    same_cell;
        logic    walk_last;
        logic    out_free;
    } pfe_stat_t;

    // row of a cell index 0..24
    function automatic logic [2:0] pfe_row(input logic [4:0] pos);
        logic [2:0] row;
        if (pos >= 5'd20) begin
            row = 3'd4;
        end else if (pos >= 5'd15) begin
            row = 3'd3;
        end else if (pos >= 5'd10) begin
            row = 3'd2;
        end else if (pos >= 5'd5) begin
            row = 3'd1;
        end else begin
            row = 3'd0;
        end
        return row;
    endfunction

    function automatic logic [2:0] pfe_col(input logic [4:0] pos, input logic [2:0] row);
        logic [4:0] diff;
        diff = pos - {row, 2'b00} - {2'b00, row};
        return diff[2:0];
    endfunction

    function automatic logic [2:0] pfe_inc5(input logic [2:0] x);
        return (x == 3'd4) ? 3'd0 : x + 3'd1;
    endfunction

    function automatic logic [4:0] pfe_cell(input logic [2:0] row, input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

endpackage

`default_nettype wire

/* rtl/pfe_ctrl.sv */
`default_nettype none

module pfe_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire pfe_pkg::pfe_stat_t stat,
    output pfe_pkg::pfe_cmd_t      cmd
);
    import pfe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_POS,
        S_CELL,
        S_PUSH
    } state_t;

    state_t state_reg, state_next;
    logic   tready_reg, tready_next;

    assign s_tready = tready_reg;

    always_comb begin
        state_next  = state_reg;
        tready_next = tready_reg;
        cmd         = '0;
        cmd.res_sel = RES_HOLD;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && tready_reg) begin
                    cmd.load_in = 1'b1;
                    tready_next = 1'b0;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (stat.op)
                    OP_CLEAR: begin
                        cmd.clear   = 1'b1;
                        cmd.res_sel = RES_ZERO;
                        state_next  = S_PUSH;
                    end
                    OP_ADD_KEY: begin
                        cmd.add_key = 1'b1;
                        cmd.res_sel = RES_ZERO;
                        state_next  = S_PUSH;
                    end
                    OP_FINISH: begin
                        cmd.walk_start = 1'b1;
                        state_next     = S_WALK;
                    end
                    OP_ENCRYPT: begin
                        priority if (!stat.ready) begin
                            cmd.res_sel = RES_NOT_READY;
                            state_next  = S_PUSH;
                        end else if (stat.range_bad) begin
                            cmd.res_sel = RES_REJECT;
                            state_next  = S_PUSH;
                        end else begin
                            cmd.pos_rd = 1'b1;
                            state_next = S_POS;
                        end
                    end
                    default: state_next = S_PUSH;
                endcase
            end
            S_WALK: begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last) begin
                    cmd.res_sel = RES_ZERO;
                    state_next  = S_PUSH;
                end
            end
            S_POS: begin
                if (stat.same_cell) begin
                    cmd.res_sel = RES_REJECT;
                    state_next  = S_PUSH;
                end else begin
                    cmd.cell_rd = 1'b1;
                    state_next  = S_CELL;
                end
            end
            S_CELL: begin
                cmd.res_sel = RES_CIPHER;
                state_next  = S_PUSH;
            end
            S_PUSH: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    tready_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            tready_reg <= 1'b1;
        end else begin
            state_reg  <= state_next;
            tready_reg <= tready_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/pfe_dpath.sv */
`default_nettype none

module pfe_dpath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [1:0]        in_op,
    input  wire logic [4:0]        in_a,
    input  wire logic [4:0]        in_b,
    input  wire pfe_pkg::pfe_cmd_t cmd,
    output pfe_pkg::pfe_stat_t     stat,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [15:0]            m_tdata,
    output logic [1:0]             m_tuser
);
    import pfe_pkg::*;

    // request registers
    pfe_op_t             op_reg;
    logic [LETTER_W-1:0] a_reg;
    logic [LETTER_W-1:0] b_reg;

    // square state
    logic [LETTER_W-1:0] pos_mem  [LETTER_COUNT];
    logic [LETTER_W-1:0] cell_mem [CELL_COUNT];
    logic [LETTER_COUNT-1:0] vld_reg;
    logic [4:0]          fill_reg;
    logic                ready_reg;
    logic [4:0]          pos_i_reg;
    logic [4:0]          walk_reg;

    // encrypt pipeline
    logic [4:0]          pa_reg, pb_reg;
    logic [LETTER_W-1:0] ca_reg, cb_reg;

    // result and output
    logic [LETTER_W-1:0] res_a_reg, res_b_reg;
    pfe_status_t         res_st_reg;
    logic                m_tvalid_reg;
    logic [15:0]         m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    logic [LETTER_W-1:0] key_letter, place_letter, pos_wa;
    logic [4:0]          pos_wd;
    logic                place_ok, place_en, walk_j, pos_we;
    logic [2:0]          ra, rb, ka, kb;
    logic [4:0]          qa, qb;
    logic                out_free;

    assign key_letter   = (a_reg == LET_J) ? LET_I : a_reg;
    assign place_letter = cmd.add_key ? key_letter : walk_reg;
    assign place_ok     = (place_letter < 5'(LETTER_COUNT)) && (fill_reg < 5'(CELL_COUNT))
                          && !vld_reg[place_letter];
    assign walk_j       = cmd.walk_step && (walk_reg == LET_J);
    assign place_en     = (cmd.add_key || (cmd.walk_step && walk_reg != LET_J)) && place_ok;
    assign pos_we       = place_en || walk_j;
    assign pos_wa       = walk_j ? LET_J : place_letter;
    assign pos_wd       = walk_j ? pos_i_reg : fill_reg;

    // Playfair substitution on the two looked-up cells
    always_comb begin
        ra = pfe_row(pa_reg);
        rb = pfe_row(pb_reg);
        ka = pfe_col(pa_reg, ra);
        kb = pfe_col(pb_reg, rb);
        priority if (ra == rb) begin
            qa = pfe_cell(ra, pfe_inc5(ka));
            qb = pfe_cell(rb, pfe_inc5(kb));
        end else if (ka == kb) begin
            qa = pfe_cell(pfe_inc5(ra), ka);
            qb = pfe_cell(pfe_inc5(rb), kb);
        end else begin
            qa = pfe_cell(ra, kb);
            qb = pfe_cell(rb, ka);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    assign stat.op        = op_reg;
    assign stat.ready     = ready_reg;
    assign stat.range_bad = (a_reg >= 5'(LETTER_COUNT)) || (b_reg >= 5'(LETTER_COUNT));
    assign stat.same_cell = (pa_reg == pb_reg);
    assign stat.walk_last = (walk_reg == 5'(LETTER_COUNT - 1));
    assign stat.out_free  = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // memories
    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
        end
        if (cmd.pos_rd) begin
            pa_reg <= pos_mem[a_reg];
            pb_reg <= pos_mem[b_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (place_en) begin
            cell_mem[fill_reg] <= place_letter;
        end
        if (cmd.cell_rd) begin
            ca_reg <= cell_mem[qa];
            cb_reg <= cell_mem[qb];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg <= pfe_op_t'(in_op);
            a_reg  <= in_a;
            b_reg  <= in_b;
        end
        if (place_en && place_letter == LET_I) begin
            pos_i_reg <= fill_reg;
        end
        if (cmd.walk_start) begin
            walk_reg <= '0;
        end else if (cmd.walk_step) begin
            walk_reg <= walk_reg + 5'd1;
        end
        unique case (cmd.res_sel)
            RES_HOLD: ;
            RES_ZERO: begin
                res_a_reg  <= '0;
                res_b_reg  <= '0;
                res_st_reg <= ST_OK;
            end
            RES_REJECT: begin
                res_a_reg  <= '0;
                res_b_reg  <= '0;
                res_st_reg <= ST_REJECT;
            end
            RES_NOT_READY: begin
                res_a_reg  <= '0;
                res_b_reg  <= '0;
                res_st_reg <= ST_NOT_READY;
            end
            RES_CIPHER: begin
                res_a_reg  <= ca_reg;
                res_b_reg  <= cb_reg;
                res_st_reg <= ST_OK;
            end
            default: ;
        endcase
        if (cmd.load_out) begin
            m_tdata_reg <= {6'b0, res_b_reg, res_a_reg};
            m_tuser_reg <= res_st_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            fill_reg     <= '0;
            ready_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                vld_reg   <= '0;
                fill_reg  <= '0;
                ready_reg <= 1'b0;
            end else begin
                if (pos_we) begin
                    vld_reg[pos_wa] <= 1'b1;
                end
                if (place_en) begin
                    fill_reg <= fill_reg + 5'd1;
                end
                if (cmd.walk_step && stat.walk_last) begin
                    ready_reg <= 1'b1;
                end
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/playfair_digraph_encrypt.sv */
`default_nettype none
// Playfair digraph encryptor: builds a 5x5 key square, then encrypts letter pairs.
// Input stream: s_tuser carries the command (clear, add key letter, finish, encrypt),
// s_tdata the two letters (0=A .. 25=Z). Every request yields exactly one result on
// the m_ stream: two cipher letters in m_tdata and a status code in m_tuser
// (ok, pair rejected, square not finished).
// Encrypt steps through position lookup, cell lookup, result and push. Finish takes
// longest because the fill sequencer walks all 26 letters one a cycle through the
// single position write port.
// One request is in flight at a time; the next is taken once the result sits in
// the output register, even while the receiver has not yet taken it.
// Reset empties the square (all letters absent, no cells filled, not finished)
// and drops any pending result. A stalled receiver holds the result in the
// output register; the block then finishes at most one more request and waits
// with s_tready low until the output register frees up.
module playfair_digraph_encrypt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [4:0] letter_a, [9:5] letter_b, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [4:0] cipher_a, [9:5] cipher_b, rest zero
    output logic [1:0]       m_tuser    // [1:0] status
);
    import pfe_pkg::*;

    pfe_cmd_t  cmd;
    pfe_stat_t stat;

    // sequence each request: decode, walk or lookups, push to output
    pfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold the square, position table and output register
    pfe_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_op    (s_tuser),
        .in_a     (s_tdata[4:0]),
        .in_b     (s_tdata[9:5]),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

/* sim/playfair_digraph_encrypt_tb.sv */
module playfair_digraph_encrypt_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfe_pkg::*;

    localparam int SQUARE_SIDE  = 5;
    localparam int ABSENT_CELL  = 31;
    localparam int DRAIN_CYCLES = 40;   // finish is the slowest request

    // one result as it leaves the m_ stream
    typedef struct packed {
        logic [4:0]  ca;
        logic [4:0]  cb;
        pfe_status_t st;
    } cipher_res_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [4:0] letter_a, [9:5] letter_b, rest zero
    logic [1:0]  s_tuser  = '0;     // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [4:0] cipher_a, [9:5] cipher_b, rest zero
    logic [1:0]  m_tuser;           // [1:0] status

    // predictor copy of the key square
    logic [4:0]  square_letter [CELL_COUNT];
    logic [4:0]  letter_cell [LETTER_COUNT];
    int          filled;
    logic        square_done;

    cipher_res_t cipher_due [$];

    bit          feed_stall = 1'b1;
    bit          sink_stall = 1'b1;
    bit          took;
    int          sink_hold;
    cipher_res_t want;

    int          mismatches;
    int          n_requests;
    int          n_enciphered;
    int          n_rejected;
    int          n_not_ready;

    always #6 aclk = ~aclk;

    playfair_digraph_encrypt dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ---------------------------------------------------------------- predictor

    task automatic clear_square();
        foreach (letter_cell[i]) letter_cell[i] = 5'(ABSENT_CELL);
        filled      = 0;
        square_done = 1'b0;
    endtask

    // place a letter only if it is a real letter, new, and the square has room
    task automatic place_key(input logic [4:0] key);
        if (key >= LETTER_COUNT || filled >= CELL_COUNT) return;
        if (letter_cell[key] != 5'(ABSENT_CELL)) return;
        letter_cell[key]      = 5'(filled);
        square_letter[filled] = key;
        filled++;
    endtask

    // update the square for one request and queue the result it must produce
    task automatic apply_request(input pfe_op_t op, input logic [4:0] la,
                                 input logic [4:0] lb);
        cipher_res_t r;
        int c, pa, pb, ra, rb, ka, kb, qa, qb;
        r.ca = '0;
        r.cb = '0;
        r.st = ST_OK;
        case (op)
            OP_CLEAR: begin
                clear_square();
            end
            OP_ADD_KEY: begin
                place_key((la == LET_J) ? LET_I : la);
            end
            OP_FINISH: begin
                // append the unused letters in order, skip J, then fold J onto I
                for (c = 0; c < LETTER_COUNT; c++) begin
                    if (5'(c) != LET_J) place_key(5'(c));
                end
                letter_cell[LET_J] = letter_cell[LET_I];
                square_done = 1'b1;
            end
            default: begin
                if (!square_done) begin
                    r.st = ST_NOT_READY;
                end else if (la >= LETTER_COUNT || lb >= LETTER_COUNT) begin
                    r.st = ST_REJECT;
                end else begin
                    pa = letter_cell[la];
                    pb = letter_cell[lb];
                    if (pa >= CELL_COUNT || pb >= CELL_COUNT || pa == pb) begin
                        r.st = ST_REJECT;
                    end else begin
                        ra = pa / SQUARE_SIDE;
                        ka = pa % SQUARE_SIDE;
                        rb = pb / SQUARE_SIDE;
                        kb = pb % SQUARE_SIDE;
                        if (ra == rb) begin
                            // same row: step right with wrap
                            qa = ra * SQUARE_SIDE + (ka + 1) % SQUARE_SIDE;
                            qb = rb * SQUARE_SIDE + (kb + 1) % SQUARE_SIDE;
                        end else if (ka == kb) begin
                            // same column: step down with wrap
                            qa = ((ra + 1) % SQUARE_SIDE) * SQUARE_SIDE + ka;
                            qb = ((rb + 1) % SQUARE_SIDE) * SQUARE_SIDE + kb;
                        end else begin
                            // rectangle: trade columns
                            qa = ra * SQUARE_SIDE + kb;
                            qb = rb * SQUARE_SIDE + ka;
                        end
                        r.ca = square_letter[qa];
                        r.cb = square_letter[qb];
                    end
                end
            end
        endcase
        case (r.st)
            ST_OK:        if (op == OP_ENCRYPT) n_enciphered++;
            ST_REJECT:    n_rejected++;
            ST_NOT_READY: n_not_ready++;
            default:      ;
        endcase
        cipher_due.push_back(r);
    endtask

    // ---------------------------------------------------------------- stimulus

    // Present one request, after a random gap while feed_stall is set; hold it until the handshake.
    // s_tready is sampled at the falling edge, so a high value there means the
    // request is taken at the next rising edge.
    task automatic send_request(input pfe_op_t op, input logic [4:0] la,
                                input logic [4:0] lb);
        int gap;
        gap = feed_stall ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, lb, la};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        apply_request(op, la, lb);
        n_requests++;
    endtask

    // mostly real letters, now and then a code above Z
    function automatic logic [4:0] pick_letter();
        if ($urandom_range(0, 19) == 0) return 5'($urandom_range(26, 31));
        return 5'($urandom_range(0, 25));
    endfunction

    task automatic test_not_ready();
        // nothing built yet
        send_request(OP_ENCRYPT, 5'd0, 5'd25);
    endtask

    task automatic test_square_build();
        send_request(OP_ADD_KEY, LET_J, 5'd31);     // J lands as I
        send_request(OP_ADD_KEY, 5'd25, 5'd0);      // Z
        send_request(OP_ENCRYPT, 5'd25, 5'd8);      // partial square, still not ready
        send_request(OP_ADD_KEY, 5'd0, 5'd0);       // A
        send_request(OP_ADD_KEY, 5'd25, 5'd0);      // repeated Z, dropped
        send_request(OP_ADD_KEY, 5'd31, 5'd31);     // not a letter, dropped
        send_request(OP_ADD_KEY, 5'd26, 5'd0);
        send_request(OP_FINISH, 5'd0, 5'd0);
        send_request(OP_FINISH, 5'd31, 5'd31);      // repeat finish places nothing
        send_request(OP_ADD_KEY, 5'd1, 5'd0);       // square done, dropped
    endtask

    // square now reads I Z A B C / D E F G H / K L M N O / P Q R S T / U V W X Y
    task automatic test_cipher_rules();
        send_request(OP_ENCRYPT, 5'd8, 5'd2);       // I C: same row, wrap right
        send_request(OP_ENCRYPT, 5'd0, 5'd5);       // A F: same column
        send_request(OP_ENCRYPT, 5'd8, 5'd20);      // I U: same column, wrap down
        send_request(OP_ENCRYPT, 5'd25, 5'd24);     // Z Y: rectangle
        send_request(OP_ENCRYPT, LET_J, 5'd19);     // J takes the cell of I
        send_request(OP_ENCRYPT, 5'd4, 5'd4);       // double letter
        send_request(OP_ENCRYPT, LET_I, LET_J);     // I and J share a cell
        send_request(OP_ENCRYPT, 5'd31, 5'd0);      // first letter out of range
        send_request(OP_ENCRYPT, 5'd25, 5'd26);     // second letter out of range
    endtask

    task automatic test_clear();
        send_request(OP_CLEAR, 5'd31, 5'd31);
        send_request(OP_ENCRYPT, 5'd1, 5'd2);
    endtask

    // Each session clears (usually), feeds a key, finishes (usually) and then
    // encrypts a run of pairs with a little noise mixed in.
    task automatic test_random_sessions(input int target);
        int perm [LETTER_COUNT];
        int i, j, tmp, key_len, pairs;
        logic [4:0] la, lb;
        while (n_requests < target) begin
            // leave some sessions free of any idling on one or both sides
            feed_stall = ($urandom_range(0, 3) != 0);
            sink_stall = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) != 0) begin
                send_request(OP_CLEAR, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            end
            case ($urandom_range(0, 2))
                0: begin
                    key_len = $urandom_range(0, 8);
                    repeat (key_len) begin
                        send_request(OP_ADD_KEY, pick_letter(), 5'($urandom_range(0, 31)));
                    end
                end
                1: begin
                    // every letter in random order fills the square, then overflow
                    for (i = 0; i < LETTER_COUNT; i++) perm[i] = i;
                    for (i = LETTER_COUNT - 1; i > 0; i--) begin
                        j       = $urandom_range(0, i);
                        tmp     = perm[i];
                        perm[i] = perm[j];
                        perm[j] = tmp;
                    end
                    for (i = 0; i < LETTER_COUNT; i++) begin
                        send_request(OP_ADD_KEY, 5'(perm[i]), 5'($urandom_range(0, 31)));
                    end
                    repeat ($urandom_range(0, 3)) begin
                        send_request(OP_ADD_KEY, pick_letter(), 5'd0);
                    end
                end
                default: begin
                    key_len = $urandom_range(10, 30);
                    repeat (key_len) begin
                        send_request(OP_ADD_KEY, pick_letter(), 5'($urandom_range(0, 31)));
                    end
                end
            endcase
            if ($urandom_range(0, 9) != 0) begin
                send_request(OP_FINISH, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            end
            pairs = $urandom_range(5, 40);
            repeat (pairs) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_request(pfe_op_t'($urandom_range(0, 3)),
                                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
                end else begin
                    la = pick_letter();
                    lb = pick_letter();
                    if ($urandom_range(0, 7) == 0) lb = la;
                    if ($urandom_range(0, 15) == 0) begin
                        la = LET_I;
                        lb = LET_J;
                    end
                    send_request(OP_ENCRYPT, la, lb);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- checking

    // m_ handshake seen at the falling edge completes at the next rising edge
    always @(negedge aclk) begin
        took = aresetn && m_tvalid && m_tready;
        if (took) begin
            if (cipher_due.size() == 0) begin
                $error("result with no request pending: cipher_a=%0d cipher_b=%0d status=%0d",
                       m_tdata[4:0], m_tdata[9:5], m_tuser);
                mismatches++;
            end else begin
                want = cipher_due.pop_front();
                if (m_tdata[4:0] !== want.ca) begin
                    $error("cipher_a: expected %0d, got %0d", want.ca, m_tdata[4:0]);
                    mismatches++;
                end
                if (m_tdata[9:5] !== want.cb) begin
                    $error("cipher_b: expected %0d, got %0d", want.cb, m_tdata[9:5]);
                    mismatches++;
                end
                if (m_tuser !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // receiver: after each result, stall for a random number of cycles if sink_stall is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold = 0;
        end else begin
            if (took) sink_hold = sink_stall ? $urandom_range(0, 8) : 0;
            if (sink_hold > 0) begin
                m_tready  <= 1'b0;
                sink_hold = sink_hold - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        foreach (square_letter[i]) square_letter[i] = '0;
        clear_square();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_not_ready();
        test_square_build();
        test_cipher_rules();
        test_clear();
        test_random_sessions(2000);
        s_tvalid <= 1'b0;

        // drain, then give a stray result time to show up
        while (cipher_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests sent: %0d pairs enciphered, %0d rejected, %0d before finish",
                 n_requests, n_enciphered, n_rejected, n_not_ready);
        $display("random idling on both streams, full and partial keys, noise commands");
        if (mismatches == 0 && cipher_due.size() == 0) begin
            $display("playfair_digraph_encrypt_tb: clean");
        end else begin
            $display("playfair_digraph_encrypt_tb: errors");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("timeout with %0d results outstanding", cipher_due.size());
        $display("playfair_digraph_encrypt_tb: errors");
        $finish;
    end

endmodule

/* files.f */
rtl/pfe_pkg.sv
rtl/pfe_ctrl.sv
rtl/pfe_dpath.sv
rtl/playfair_digraph_encrypt.sv
sim/playfair_digraph_encrypt_tb.sv
